// ----- sv/dual_motor_command_interlock_assert.svh -----
// Assertion macros for the dual motor command interlock.
`ifndef DUAL_MOTOR_COMMAND_INTERLOCK_ASSERT_SVH
`define DUAL_MOTOR_COMMAND_INTERLOCK_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define DMCI_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("interlock check failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define DMCI_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("interlock check failed");
`endif

// ----- sv/dmci_pkg.sv -----
// Package: command codes, register indexes, constants and struct types of the interlock.
package dmci_pkg;
  localparam logic [2:0] CMD_PLAN    = 3'd0;
  localparam logic [2:0] CMD_TRY_ARM = 3'd1;
  localparam logic [2:0] CMD_ARM     = 3'd2;
  localparam logic [2:0] CMD_DISARM  = 3'd3;
  localparam logic [2:0] CMD_CLEAR   = 3'd4;
  localparam logic [2:0] CMD_REPORT  = 3'd5;

  localparam logic [2:0] REG_LIMIT   = 3'd0;
  localparam logic [2:0] REG_INVERT  = 3'd1;
  localparam logic [2:0] REG_IMU     = 3'd2;
  localparam logic [2:0] REG_COMMAND = 3'd3;
  localparam logic [2:0] REG_NODE    = 3'd4;

  localparam logic [30:0] LIMIT_RESET = 31'h40A0_0000;
  localparam logic [30:0] EXP_ALL     = 31'h7F80_0000;
  localparam logic [31:0] SIGN_BIT    = 32'h8000_0000;

  typedef struct packed {
    logic [30:0] limit;
    logic [1:0]  invert;
    logic [31:0] imu_lim;
    logic [31:0] cmd_lim;
    logic [31:0] node_lim;
  } cfg_t;

  typedef struct packed {
    logic        armed;
    logic        latched;
    logic        whole;
    logic [31:0] count;
  } state_t;

  typedef struct packed {
    logic [13:0] reject_bits;
    logic        send;
    logic [31:0] sequence_res;
    logic [31:0] current_a_bits;
    logic [31:0] current_b_bits;
    logic        arm_granted;
    logic        armed_now;
    logic        latched_now;
    logic        pair_intact;
  } result_t;
endpackage

// ----- sv/dual_motor_command_interlock.sv -----
// Top level: dual motor command interlock with registered result stage.
//
// Channel | Direction | Handshake           | Payload
// in_     | input     | in_valid/in_ready   | cmd, times, faults, flags, current
// out_    | output    | out_valid/out_ready | reject bits, send, sequence, currents, arm and state flags
// cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One item per cycle while the output is not stalled: decision logic runs between
// the input ports and the result register. The result register is the only
// stage; a new beat is taken when it is empty or drained in that cycle.
// Synchronous reset returns flags, sequence counter and config to their defaults.
// Config writes are always ready.
module dual_motor_command_interlock (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_cmd,
  input  logic [63:0] in_now_time,
  input  logic [63:0] in_imu_time,
  input  logic [63:0] in_command_time,
  input  logic [63:0] in_feedback_a_time,
  input  logic [63:0] in_feedback_b_time,
  input  logic [7:0]  in_fault_a,
  input  logic [7:0]  in_fault_b,
  input  logic [2:0]  in_link_flags,
  input  logic [31:0] in_requested_current_bits,
  input  logic [8:0]  in_health_flags,
  input  logic [1:0]  in_report_sent,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [13:0] out_reject_bits,
  output logic        out_send,
  output logic [31:0] out_sequence_res,
  output logic [31:0] out_current_a_bits,
  output logic [31:0] out_current_b_bits,
  output logic        out_arm_granted,
  output logic        out_armed_now,
  output logic        out_latched_now,
  output logic        out_pair_intact,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  dmci_pkg::cfg_t    cfg;
  dmci_pkg::state_t  st_r, st_nxt;
  dmci_pkg::result_t res_r, res_nxt;
  logic              valid_r;
  logic              take;
  logic [3:0]        stale;
  logic [30:0]       mag;
  logic [13:0]       plan_m;
  logic [9:0]        arm_m;
  logic [31:0]       cnt_inc;

  assign cfg_ready = 1'b1;
  assign in_ready  = !valid_r || out_ready;
  assign take      = in_valid && in_ready;

  dmci_cfg u_cfg (
    .clk(clk), .rst_n(rst_n), .wr(cfg_valid), .idx(cfg_index),
    .data(cfg_data), .cfg(cfg)
  );

  dmci_stale u_imu (.now(in_now_time), .last(in_imu_time),
    .limit(cfg.imu_lim), .stale(stale[0]));
  dmci_stale u_cmd (.now(in_now_time), .last(in_command_time),
    .limit(cfg.cmd_lim), .stale(stale[1]));
  dmci_stale u_nda (.now(in_now_time), .last(in_feedback_a_time),
    .limit(cfg.node_lim), .stale(stale[2]));
  dmci_stale u_ndb (.now(in_now_time), .last(in_feedback_b_time),
    .limit(cfg.node_lim), .stale(stale[3]));

  // build deny masks
  assign mag = in_requested_current_bits[30:0];
  always_comb begin
    plan_m[0]  = !st_r.armed;
    plan_m[1]  = st_r.latched;
    plan_m[2]  = !st_r.whole;
    plan_m[3]  = !in_link_flags[0];
    plan_m[7:4] = stale;
    plan_m[8]  = |in_fault_a;
    plan_m[9]  = |in_fault_b;
    plan_m[10] = in_link_flags[1];
    plan_m[11] = in_link_flags[2];
    plan_m[12] = mag >= dmci_pkg::EXP_ALL;
    plan_m[13] = !(mag >= dmci_pkg::EXP_ALL) && (cfg.limit < dmci_pkg::EXP_ALL)
                 && (mag > cfg.limit);
    arm_m[3:0] = ~in_health_flags[3:0];
    arm_m[4]   = st_r.latched || !st_r.whole;
    arm_m[9:5] = ~in_health_flags[8:4];
  end
  assign cnt_inc = st_r.count + 32'd1;

  // decide state update and result
  always_comb begin
    st_nxt  = st_r;
    res_nxt = '0;
    unique case (in_cmd)
      dmci_pkg::CMD_PLAN: begin
        res_nxt.reject_bits = plan_m;
        if (plan_m == 14'd0) begin
          st_nxt.count           = cnt_inc;
          res_nxt.send           = 1'b1;
          res_nxt.sequence_res   = cnt_inc;
          res_nxt.current_a_bits = in_requested_current_bits
                                   ^ (cfg.invert[0] ? dmci_pkg::SIGN_BIT : 32'd0);
          res_nxt.current_b_bits = in_requested_current_bits
                                   ^ (cfg.invert[1] ? dmci_pkg::SIGN_BIT : 32'd0);
        end
      end
      dmci_pkg::CMD_TRY_ARM: begin
        res_nxt.reject_bits = {4'd0, arm_m};
        if (arm_m == 10'd0) begin
          st_nxt.armed        = 1'b1;
          res_nxt.arm_granted = 1'b1;
        end
      end
      dmci_pkg::CMD_ARM:    st_nxt.armed = 1'b1;
      dmci_pkg::CMD_DISARM: st_nxt.armed = 1'b0;
      dmci_pkg::CMD_CLEAR: begin
        st_nxt.armed   = 1'b0;
        st_nxt.latched = 1'b0;
        st_nxt.whole   = 1'b1;
      end
      dmci_pkg::CMD_REPORT: begin
        if (in_report_sent[0] == in_report_sent[1]) begin
          st_nxt.whole = 1'b1;
        end else begin
          st_nxt.latched = 1'b1;
          st_nxt.whole   = 1'b0;
        end
      end
      default: ;
    endcase
    res_nxt.armed_now   = st_nxt.armed;
    res_nxt.latched_now = st_nxt.latched;
    res_nxt.pair_intact = st_nxt.whole;
  end

  // advance state and result register per accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= '{armed: 1'b0, latched: 1'b0, whole: 1'b1, count: 32'd0};
      valid_r <= 1'b0;
    end else begin
      if (take) begin
        st_r    <= st_nxt;
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = valid_r;
  assign out_reject_bits    = res_r.reject_bits;
  assign out_send           = res_r.send;
  assign out_sequence_res   = res_r.sequence_res;
  assign out_current_a_bits = res_r.current_a_bits;
  assign out_current_b_bits = res_r.current_b_bits;
  assign out_arm_granted    = res_r.arm_granted;
  assign out_armed_now      = res_r.armed_now;
  assign out_latched_now    = res_r.latched_now;
  assign out_pair_intact    = res_r.pair_intact;

`include "dual_motor_command_interlock_assert.svh"
  `DMCI_ASSERT_IMP(a_send_clean, out_valid && out_send, out_reject_bits == 14'd0)
  `DMCI_ASSERT_IMP(a_latch_split, out_valid && out_latched_now == 1'b0, out_pair_intact)
  `DMCI_ASSERT_NXT(a_seq_step, take && in_cmd == dmci_pkg::CMD_PLAN && plan_m == 14'd0, out_sequence_res == st_r.count)
  `DMCI_ASSERT_NXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(res_r))
endmodule

// ----- sv/dmci_cfg.sv -----
// Configuration register file of the interlock.
module dmci_cfg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr,
  input  logic [2:0]       idx,
  input  logic [31:0]      data,
  output dmci_pkg::cfg_t   cfg
);
  dmci_pkg::cfg_t cfg_r;
  assign cfg = cfg_r;

  // write one register per beat, ignore unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.limit    <= dmci_pkg::LIMIT_RESET;
      cfg_r.invert   <= 2'd0;
      cfg_r.imu_lim  <= 32'd20000;
      cfg_r.cmd_lim  <= 32'd50000;
      cfg_r.node_lim <= 32'd50000;
    end else if (wr) begin
      unique case (idx)
        dmci_pkg::REG_LIMIT:   cfg_r.limit    <= data[30:0];
        dmci_pkg::REG_INVERT:  cfg_r.invert   <= data[1:0];
        dmci_pkg::REG_IMU:     cfg_r.imu_lim  <= data;
        dmci_pkg::REG_COMMAND: cfg_r.cmd_lim  <= data;
        dmci_pkg::REG_NODE:    cfg_r.node_lim <= data;
        default: ;
      endcase
    end
  end
endmodule

// ----- sv/dmci_stale.sv -----
// Freshness check of one timestamp against now.
module dmci_stale (
  input  logic [63:0] now,
  input  logic [63:0] last,
  input  logic [31:0] limit,
  output logic        stale
);
  logic [64:0] diff;
  // future stamps borrow out of the subtract and count as stale
  assign diff  = {1'b0, now} - {1'b0, last};
  assign stale = diff[64] | (diff[63:0] > {32'd0, limit});
endmodule
